FILE: design/stack_frame_vm_executor_core_defines.svh
// assertion macros shared by the executor rtl
`ifndef STACK_FRAME_VM_EXECUTOR_CORE_DEFINES_SVH
`define STACK_FRAME_VM_EXECUTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SFVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SFVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sfvm_pkg.sv
// types, constants and address resolution for the stack frame executor
`timescale 1ns / 1ps
`default_nettype none
package sfvm_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_DEPTH  = 1024;
  localparam int PROG_DEPTH  = 4096;
  localparam int GLOBAL_BIT  = 30;

  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int DIDX_W = $clog2(DATA_DEPTH);
  localparam int IDX_W  = (SIDX_W > DIDX_W) ? SIDX_W : DIDX_W;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IP_W   = 12;
  localparam int DSZ_W  = 11;

  localparam logic [4:0] OP_IN    = 5'd0;
  localparam logic [4:0] OP_OUT   = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_SET   = 5'd3;
  localparam logic [4:0] OP_LABEL = 5'd4;
  localparam logic [4:0] OP_SUB   = 5'd5;
  localparam logic [4:0] OP_MUL   = 5'd6;
  localparam logic [4:0] OP_DIV   = 5'd7;
  localparam logic [4:0] OP_MOV   = 5'd8;
  localparam logic [4:0] OP_IFGE  = 5'd9;
  localparam logic [4:0] OP_IFLE  = 5'd10;
  localparam logic [4:0] OP_IFL   = 5'd11;
  localparam logic [4:0] OP_IFG   = 5'd12;
  localparam logic [4:0] OP_IFE   = 5'd13;
  localparam logic [4:0] OP_IFNE  = 5'd14;
  localparam logic [4:0] OP_GOTO  = 5'd15;
  localparam logic [4:0] OP_PARAM = 5'd16;
  localparam logic [4:0] OP_MTA   = 5'd17;
  localparam logic [4:0] OP_MFA   = 5'd18;
  localparam logic [4:0] OP_ALLOC = 5'd19;
  localparam logic [4:0] OP_RET   = 5'd20;
  localparam logic [4:0] OP_CHAR  = 5'd21;
  localparam logic [4:0] OP_CALL  = 5'd22;
  localparam logic [4:0] OP_CLN   = 5'd23;
  localparam logic [4:0] OP_CLNNR = 5'd24;
  localparam logic [4:0] OP_EXIT  = 5'd25;

  localparam logic [2:0] FLT_NONE = 3'd0;
  localparam logic [2:0] FLT_DIVZ = 3'd1;
  localparam logic [2:0] FLT_OVF  = 3'd2;
  localparam logic [2:0] FLT_UND  = 3'd3;
  localparam logic [2:0] FLT_ADDR = 3'd4;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

  typedef struct packed {
    logic             ok;
    logic             glob;
    logic [IDX_W-1:0] idx;
  } loc_t;

  // global bit selects the data store, otherwise frame relative stack entry
  function automatic loc_t locate(logic [31:0] addr, logic [CNT_W-1:0] cnt,
                                  logic [CNT_W-1:0] fb, logic [DSZ_W-1:0] dsize);
    logic [31:0]        gi;
    logic signed [33:0] si;
    loc_t               l;
    gi = addr;
    gi[GLOBAL_BIT] = 1'b0;
    si = $signed({{(34 - CNT_W){1'b0}}, fb}) + $signed({{2{addr[31]}}, addr});
    l.glob = !addr[31] && addr[GLOBAL_BIT];
    if (l.glob) begin
      l.ok  = (gi < {{(32 - DSZ_W){1'b0}}, dsize}) && (gi < 32'(DATA_DEPTH));
      l.idx = gi[IDX_W-1:0];
    end else begin
      l.ok  = !si[33] && (si < $signed({{(34 - CNT_W){1'b0}}, cnt}));
      l.idx = si[IDX_W-1:0];
    end
    return l;
  endfunction

endpackage
`default_nettype wire

FILE: design/sfvm_if.sv
// instruction and result channels
`timescale 1ns / 1ps
`default_nettype none
interface sfvm_cmd_if;
  logic               valid;
  logic               ready;
  logic [4:0]         command;
  logic signed [31:0] operand_d;
  logic signed [31:0] operand_s;
  logic signed [31:0] operand_t;
  logic signed [31:0] input_value;
  modport source (output valid, command, operand_d, operand_s, operand_t, input_value,
                  input ready);
  modport sink (input valid, command, operand_d, operand_s, operand_t, input_value,
                output ready);
endinterface

interface sfvm_res_if;
  logic               valid;
  logic               ready;
  logic [11:0]        next_ip;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               print_is_char;
  logic               halted;
  logic [2:0]         fault;
  modport source (output valid, next_ip, print_valid, print_value, print_is_char, halted,
                  fault, input ready);
  modport sink (input valid, next_ip, print_valid, print_value, print_is_char, halted,
                fault, output ready);
endinterface
`default_nettype wire

FILE: design/sfvm_alu.sv
// shared add, subtract, multiply and compare unit
`timescale 1ns / 1ps
`default_nettype none
module sfvm_alu (
  input  wire logic [1:0]          op,
  input  wire logic [31:0]         x,
  input  wire logic [31:0]         y,
  output logic [31:0]              res,
  output sfvm_pkg::alu_flags_t     flags
);
  import sfvm_pkg::*;

  logic [63:0] prod;

  assign prod = x * y;

  always_comb begin
    case (op)
      ALU_ADD: res = x + y;
      ALU_SUB: res = x - y;
      ALU_MUL: res = prod[31:0];
      default: res = x + y;
    endcase
  end

  assign flags.lt = $signed(x) < $signed(y);
  assign flags.eq = (x == y);
endmodule
`default_nettype wire

FILE: design/sfvm_div.sv
// radix-2 restoring divider, truncates toward zero
`timescale 1ns / 1ps
`default_nettype none
module sfvm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[31]};
  assign diff = shifted - {1'b0, dvs};
  assign done = busy && (cnt == 6'd0);
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 6'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      rem <= 33'd0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
        if (!diff[32]) begin
          rem <= diff;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[30:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/stack_frame_vm_executor_core.sv
// stack frame executor: sequencer, stack and data stores, result register
// jumps, print and exit finish from dispatch, and a command after halt answers from idle;
// memory operands add read and write states; divide waits on the shared divider, alloc pushes
// words one at a time and call pushes three; all memory traffic goes through one read and one write port per store
// one item at a time: the next is taken after the result beat is taken
// rst clears ip, frame base, stack count and halt; stores are not cleared
`timescale 1ns / 1ps
`default_nettype none
module stack_frame_vm_executor_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [10:0]             cfg_data,
  sfvm_cmd_if.sink                     cmd,
  sfvm_res_if.source                   res
);
  import sfvm_pkg::*;
  `include "stack_frame_vm_executor_core_defines.svh"

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_RD1   = 5'd2;
  localparam logic [4:0] S_RD1W  = 5'd3;
  localparam logic [4:0] S_RD2   = 5'd4;
  localparam logic [4:0] S_RD2W  = 5'd5;
  localparam logic [4:0] S_EXEC  = 5'd6;
  localparam logic [4:0] S_DIVW  = 5'd7;
  localparam logic [4:0] S_WRITE = 5'd8;
  localparam logic [4:0] S_PUSH  = 5'd9;
  localparam logic [4:0] S_CALL1 = 5'd10;
  localparam logic [4:0] S_CALL2 = 5'd11;
  localparam logic [4:0] S_CALL3 = 5'd12;
  localparam logic [4:0] S_RET1  = 5'd13;
  localparam logic [4:0] S_RET2  = 5'd14;
  localparam logic [4:0] S_RET3  = 5'd15;
  localparam logic [4:0] S_RET4  = 5'd16;
  localparam logic [4:0] S_CLN   = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  // architectural state
  logic [4:0]       state, state_next;
  logic [IP_W-1:0]  instr_ptr, instr_ptr_next;
  logic [CNT_W-1:0] frame_base, frame_base_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic             stopped, stopped_next;
  logic [DSZ_W-1:0] data_size;

  // latched instruction and work registers
  logic [4:0]       op, op_next;
  logic [31:0]      rd, rd_next, rs, rs_next, rt, rt_next, riv, riv_next;
  logic [31:0]      a, a_next, b, b_next, c, c_next;
  logic [31:0]      addr1, addr1_next, addr2, addr2_next;
  logic [31:0]      waddr, waddr_next, wval, wval_next;
  logic [CNT_W-1:0] wcnt, wcnt_next, rem, rem_next;
  logic             glob, glob_next;

  // result register
  logic             res_valid, res_valid_next;
  logic [IP_W-1:0]  res_ip, res_ip_next;
  logic             res_pv, res_pv_next, res_pc, res_pc_next, res_halt, res_halt_next;
  logic [31:0]      res_pval, res_pval_next;
  logic [2:0]       res_fault, res_fault_next;

  // finish request
  logic             fin, f_pv, f_pc, f_halt;
  logic [IP_W-1:0]  f_next;
  logic [31:0]      f_pval;
  logic [2:0]       f_fault;

  // memories
  logic [31:0]      smem [STACK_DEPTH];
  logic [31:0]      dmem [DATA_DEPTH];
  logic             s_we, d_we;
  logic [SIDX_W-1:0] s_wa, s_ra;
  logic [DIDX_W-1:0] d_wa, d_ra;
  logic [31:0]      s_wd, d_wd, s_rdata, d_rdata, rv;

  // shared units
  logic [1:0]       alu_op;
  logic [31:0]      alu_x, alu_y, alu_res;
  alu_flags_t       alu_flags;
  logic             div_start, div_done;
  logic [31:0]      div_quo;

  logic [31:0]      loc_addr;
  logic [CNT_W-1:0] loc_cnt;
  loc_t             loc;

  logic             take;
  logic [32:0]      sum33, cnr33;
  logic [IP_W:0]    fb2, rcnt;
  logic [31:0]      ret_ra, ret_fb;

  sfvm_alu u_alu (
    .op(alu_op), .x(alu_x), .y(alu_y), .res(alu_res), .flags(alu_flags)
  );

  sfvm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_rdata <= smem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_wa] <= d_wd;
    d_rdata <= dmem[d_ra];
  end

  assign rv = glob ? d_rdata : s_rdata;
  assign loc = locate(loc_addr, loc_cnt, frame_base, data_size);

  always_comb begin
    case (op)
      OP_IFGE: take = !alu_flags.lt;
      OP_IFLE: take = alu_flags.lt || alu_flags.eq;
      OP_IFL:  take = alu_flags.lt;
      OP_IFG:  take = !alu_flags.lt && !alu_flags.eq;
      OP_IFE:  take = alu_flags.eq;
      default: take = !alu_flags.eq;
    endcase
  end

  always_comb begin
    state_next = state;
    instr_ptr_next = instr_ptr;
    frame_base_next = frame_base;
    stack_count_next = stack_count;
    stopped_next = stopped;
    op_next = op;
    rd_next = rd;
    rs_next = rs;
    rt_next = rt;
    riv_next = riv;
    a_next = a;
    b_next = b;
    c_next = c;
    addr1_next = addr1;
    addr2_next = addr2;
    waddr_next = waddr;
    wval_next = wval;
    wcnt_next = wcnt;
    rem_next = rem;
    glob_next = glob;
    res_valid_next = res_valid;
    res_ip_next = res_ip;
    res_pv_next = res_pv;
    res_pc_next = res_pc;
    res_halt_next = res_halt;
    res_pval_next = res_pval;
    res_fault_next = res_fault;
    fin = 1'b0;
    f_next = instr_ptr + IP_W'(1);
    f_pv = 1'b0;
    f_pc = 1'b0;
    f_halt = 1'b0;
    f_pval = 32'd0;
    f_fault = FLT_NONE;
    s_we = 1'b0;
    s_wa = stack_count[SIDX_W-1:0];
    s_wd = 32'd0;
    s_ra = loc.idx[SIDX_W-1:0];
    d_we = 1'b0;
    d_wa = loc.idx[DIDX_W-1:0];
    d_wd = wval;
    d_ra = loc.idx[DIDX_W-1:0];
    alu_op = ALU_SUB;
    alu_x = a;
    alu_y = b;
    div_start = 1'b0;
    loc_addr = addr1;
    loc_cnt = stack_count;
    cmd.ready = 1'b0;
    ret_ra = a;
    ret_fb = c;
    sum33 = {{(33 - CNT_W){1'b0}}, stack_count} + {1'b0, rd};
    cnr33 = 33'd1 + (rd[31] ? 33'd0 : {1'b0, rd});
    fb2 = {{(IP_W + 1 - CNT_W){1'b0}}, frame_base} + (IP_W + 1)'(2);
    rcnt = ({{(IP_W + 1 - CNT_W){1'b0}}, stack_count} > fb2) ? fb2
         : {{(IP_W + 1 - CNT_W){1'b0}}, stack_count};

    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          op_next = cmd.command;
          rd_next = cmd.operand_d;
          rs_next = cmd.operand_s;
          rt_next = cmd.operand_t;
          riv_next = cmd.input_value;
          if (stopped) begin
            fin = 1'b1;
            f_next = instr_ptr;
            f_halt = 1'b1;
          end else begin
            state_next = S_DISP;
          end
        end
      end
      S_DISP: begin
        wcnt_next = stack_count;
        waddr_next = rd;
        addr1_next = rs;
        addr2_next = rt;
        case (op)
          OP_IN: begin
            wval_next = riv;
            state_next = S_WRITE;
          end
          OP_SET: begin
            wval_next = rs;
            state_next = S_WRITE;
          end
          OP_LABEL: begin
            fin = 1'b1;
            f_next = rs[IP_W-1:0];
          end
          OP_GOTO: begin
            fin = 1'b1;
            f_next = rd[IP_W-1:0];
          end
          OP_CHAR: begin
            fin = 1'b1;
            f_pv = 1'b1;
            f_pc = 1'b1;
            f_pval = {24'd0, rd[7:0]};
          end
          OP_EXIT: begin
            fin = 1'b1;
            f_halt = 1'b1;
            f_next = instr_ptr;
          end
          OP_OUT, OP_PARAM: begin
            addr1_next = rd;
            state_next = S_RD1;
          end
          OP_IFGE, OP_IFLE, OP_IFL, OP_IFG, OP_IFE, OP_IFNE: begin
            addr1_next = rd;
            addr2_next = rs;
            state_next = S_RD1;
          end
          OP_MFA: begin
            addr1_next = rt;
            state_next = S_RD1;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV, OP_MTA: begin
            state_next = S_RD1;
          end
          OP_ALLOC: begin
            if (rd[31] || rd == 32'd0) begin
              fin = 1'b1;
            end else if (sum33 > 33'(STACK_DEPTH)) begin
              fin = 1'b1;
              f_fault = FLT_OVF;
            end else begin
              rem_next = rd[CNT_W-1:0];
              state_next = S_PUSH;
            end
          end
          OP_RET: begin
            if (rcnt < (IP_W + 1)'(3)) begin
              fin = 1'b1;
              f_fault = FLT_UND;
            end else begin
              rem_next = rcnt[CNT_W-1:0];
              wcnt_next = rcnt[CNT_W-1:0] - CNT_W'(1);
              state_next = S_RET1;
            end
          end
          OP_CALL: begin
            if ((stack_count + CNT_W'(3)) > CNT_W'(STACK_DEPTH)) begin
              fin = 1'b1;
              f_fault = FLT_OVF;
            end else begin
              state_next = S_CALL1;
            end
          end
          OP_CLN: begin
            // pop the result first, then drop s arguments
            if (stack_count == CNT_W'(0) || (!rs[31] && rs != 32'd0 &&
                {{(32 - CNT_W){1'b0}}, stack_count - CNT_W'(1)} < rs)) begin
              fin = 1'b1;
              f_fault = FLT_UND;
            end else begin
              s_ra = SIDX_W'(stack_count - CNT_W'(1));
              wcnt_next = stack_count - CNT_W'(1);
              state_next = S_CLN;
            end
          end
          OP_CLNNR: begin
            fin = 1'b1;
            if ({{(33 - CNT_W){1'b0}}, stack_count} < cnr33) begin
              f_fault = FLT_UND;
            end else begin
              stack_count_next = stack_count - cnr33[CNT_W-1:0];
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_RD1: begin
        loc_addr = addr1;
        if (!loc.ok) begin
          fin = 1'b1;
          f_fault = FLT_ADDR;
        end else begin
          glob_next = loc.glob;
          state_next = S_RD1W;
        end
      end
      S_RD1W: begin
        a_next = rv;
        case (op)
          OP_OUT: begin
            fin = 1'b1;
            f_pv = 1'b1;
            f_pval = rv;
          end
          OP_PARAM: begin
            fin = 1'b1;
            if (stack_count >= CNT_W'(STACK_DEPTH)) begin
              f_fault = FLT_OVF;
            end else begin
              s_we = 1'b1;
              s_wd = rv;
              stack_count_next = stack_count + CNT_W'(1);
            end
          end
          OP_MOV: begin
            wval_next = rv;
            state_next = S_WRITE;
          end
          default: begin
            state_next = S_RD2;
          end
        endcase
      end
      S_RD2: begin
        // array read indexes from s plus the loaded offset
        alu_op = ALU_ADD;
        alu_x = rs;
        alu_y = a;
        loc_addr = (op == OP_MFA) ? alu_res : addr2;
        if (!loc.ok) begin
          fin = 1'b1;
          f_fault = FLT_ADDR;
        end else begin
          glob_next = loc.glob;
          state_next = S_RD2W;
        end
      end
      S_RD2W: begin
        b_next = rv;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        wval_next = b;
        case (op)
          OP_ADD: begin
            alu_op = ALU_ADD;
            wval_next = alu_res;
            state_next = S_WRITE;
          end
          OP_SUB: begin
            alu_op = ALU_SUB;
            wval_next = alu_res;
            state_next = S_WRITE;
          end
          OP_MUL: begin
            alu_op = ALU_MUL;
            wval_next = alu_res;
            state_next = S_WRITE;
          end
          OP_DIV: begin
            if (b == 32'd0) begin
              fin = 1'b1;
              f_fault = FLT_DIVZ;
            end else begin
              div_start = 1'b1;
              state_next = S_DIVW;
            end
          end
          OP_MTA: begin
            alu_op = ALU_ADD;
            alu_x = rd;
            alu_y = a;
            waddr_next = alu_res;
            state_next = S_WRITE;
          end
          OP_MFA: begin
            state_next = S_WRITE;
          end
          default: begin
            fin = 1'b1;
            if (take) f_next = rt[IP_W-1:0];
          end
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          wval_next = div_quo;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        loc_addr = waddr;
        loc_cnt = wcnt;
        fin = 1'b1;
        if (!loc.ok) begin
          f_fault = FLT_ADDR;
        end else begin
          d_we = loc.glob;
          s_we = !loc.glob;
          s_wa = loc.idx[SIDX_W-1:0];
          s_wd = wval;
          if (op == OP_RET) begin
            // the result slot may land on the saved return address or frame base
            if (!loc.glob && loc.idx[SIDX_W-1:0] == SIDX_W'(rem - CNT_W'(2))) ret_ra = wval;
            if (!loc.glob && loc.idx[SIDX_W-1:0] == SIDX_W'(rem - CNT_W'(3))) ret_fb = wval;
            frame_base_next = {{(CNT_W - SIDX_W){1'b0}}, ret_fb[SIDX_W-1:0]};
            stack_count_next = rem - CNT_W'(3);
            f_next = ret_ra[IP_W-1:0] + IP_W'(1);
          end else if (op == OP_CLN) begin
            stack_count_next = (!rs[31] && rs != 32'd0) ? wcnt - rs[CNT_W-1:0] : wcnt;
          end
        end
      end
      S_PUSH: begin
        s_we = 1'b1;
        stack_count_next = stack_count + CNT_W'(1);
        rem_next = rem - CNT_W'(1);
        if (rem == CNT_W'(1)) fin = 1'b1;
      end
      S_CALL1: begin
        s_we = 1'b1;
        stack_count_next = stack_count + CNT_W'(1);
        state_next = S_CALL2;
      end
      S_CALL2: begin
        s_we = 1'b1;
        s_wd = {{(32 - CNT_W){1'b0}}, frame_base};
        stack_count_next = stack_count + CNT_W'(1);
        state_next = S_CALL3;
      end
      S_CALL3: begin
        // new frame base points at the saved return address
        s_we = 1'b1;
        s_wd = {{(32 - IP_W){1'b0}}, instr_ptr};
        stack_count_next = stack_count + CNT_W'(1);
        frame_base_next = stack_count;
        fin = 1'b1;
        f_next = rd[IP_W-1:0] + IP_W'(1);
      end
      S_RET1: begin
        s_ra = SIDX_W'(rem - CNT_W'(1));
        state_next = S_RET2;
      end
      S_RET2: begin
        wval_next = s_rdata;
        s_ra = SIDX_W'(rem - CNT_W'(2));
        state_next = S_RET3;
      end
      S_RET3: begin
        a_next = s_rdata;
        s_ra = SIDX_W'(rem - CNT_W'(3));
        state_next = S_RET4;
      end
      S_RET4: begin
        c_next = s_rdata;
        waddr_next = 32'hFFFF_FFFE;
        state_next = S_WRITE;
      end
      S_CLN: begin
        wval_next = s_rdata;
        state_next = S_WRITE;
      end
      S_DONE: begin
        if (res.ready) begin
          res_valid_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_DONE;
      res_valid_next = 1'b1;
      if (f_fault != FLT_NONE) begin
        res_ip_next = instr_ptr;
        res_pv_next = 1'b0;
        res_pc_next = 1'b0;
        res_pval_next = 32'd0;
        res_halt_next = 1'b1;
        res_fault_next = f_fault;
        // a faulting instruction leaves all other state untouched
        stack_count_next = stack_count;
        frame_base_next = frame_base;
        s_we = 1'b0;
        d_we = 1'b0;
      end else begin
        res_ip_next = f_next;
        res_pv_next = f_pv;
        res_pc_next = f_pc;
        res_pval_next = f_pval;
        res_halt_next = f_halt;
        res_fault_next = FLT_NONE;
      end
      instr_ptr_next = res_ip_next;
      stopped_next = stopped || res_halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      instr_ptr <= '0;
      frame_base <= '0;
      stack_count <= '0;
      stopped <= 1'b0;
      res_valid <= 1'b0;
      data_size <= DSZ_W'(DATA_DEPTH);
    end else begin
      state <= state_next;
      instr_ptr <= instr_ptr_next;
      frame_base <= frame_base_next;
      stack_count <= stack_count_next;
      stopped <= stopped_next;
      res_valid <= res_valid_next;
      if (cfg_we) data_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    rd <= rd_next;
    rs <= rs_next;
    rt <= rt_next;
    riv <= riv_next;
    a <= a_next;
    b <= b_next;
    c <= c_next;
    addr1 <= addr1_next;
    addr2 <= addr2_next;
    waddr <= waddr_next;
    wval <= wval_next;
    wcnt <= wcnt_next;
    rem <= rem_next;
    glob <= glob_next;
    res_ip <= res_ip_next;
    res_pv <= res_pv_next;
    res_pc <= res_pc_next;
    res_halt <= res_halt_next;
    res_pval <= res_pval_next;
    res_fault <= res_fault_next;
  end

  assign res.valid = res_valid;
  assign res.next_ip = res_ip;
  assign res.print_valid = res_pv;
  assign res.print_value = res_pval;
  assign res.print_is_char = res_pc;
  assign res.halted = res_halt;
  assign res.fault = res_fault;

  `SFVM_ASSERT_IMP(a_count_range, 1'b1, stack_count <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `SFVM_ASSERT_IMP(a_fault_halts, res.valid && res.fault != FLT_NONE, res.halted, "fault without halt")
  `SFVM_ASSERT_NXT(a_halt_sticks, res.valid && res.halted, stopped, "halt not latched")
  `SFVM_ASSERT_IMP(a_ready_no_result, cmd.ready, !res.valid, "ready while result pending")
endmodule
`default_nettype wire
